// File: hdl/madc_pkg.sv
// ----------------------------------------------------------------------------
// madc_pkg
// shared types and constants of the multichannel adc smoothing filter
// ----------------------------------------------------------------------------
package madc_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_ALPHA     = 2'd2;

   // filter modes
   localparam logic MODE_MOVING_AVG = 1'b0;
   localparam logic MODE_EMA        = 1'b1;

   // register reset values
   localparam logic [7:0]  WINDOW_LENGTH_RST = 8'd16;
   localparam logic [16:0] EMA_ALPHA_RST     = 17'd32768;
   localparam logic [16:0] ALPHA_ONE         = 17'd65536;

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int STATUS_W = 8;
   localparam int CHAN_W   = 4;
   localparam int RESULT_W = 32;
   localparam int FRAC_W   = 8;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [STATUS_W-1:0] status;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   chan;
      logic [RESULT_W-1:0] smoothed;
      logic                dropped;
   } rsp_payload_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: hdl/madc_divider.sv
// ----------------------------------------------------------------------------
// madc_divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module madc_divider #(
   parameter int DIVIDEND_W = 36,
   parameter int DIVISOR_W  = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0]      divisor,
   output madc_pkg::div_status_type  status,
   output logic [DIVIDEND_W-1:0]     quotient
);
   import madc_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // shift in the next dividend bit, subtract when the divisor fits
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// File: hdl/multichannel_adc_smoothing_filter_core.sv
// ----------------------------------------------------------------------------
// multichannel_adc_smoothing_filter_core
// per-channel moving average or exponential smoothing of 24-bit adc words
// ----------------------------------------------------------------------------
// One request transfer carries a 24-bit conversion word and the status byte;
// the low status nibble selects the channel. Each request gives exactly one
// response transfer with the channel, the smoothed value in unsigned 24.8
// (truncated) and a drop flag for channels at or above CHANNELS, which touch
// no state. Items are processed one at a time. A moving-average item waits
// on the bit-serial divider that forms sum*256/N; an exponential item uses
// the single shared 17x32 multiplier twice. A dropped item goes straight to
// completion. The response register lets the next request be taken while a
// result waits. Raw samples sit in a synchronous window memory of
// CHANNELS*WINDOW_DEPTH words; the per-channel sum, pointer, fill count,
// window length and last result sit in a second synchronous memory. No
// clearing pass is needed after reset: a per-channel valid bit and fill
// count make unwritten entries read as zero. Configuration registers may
// be written only while no item is in flight.
// ----------------------------------------------------------------------------
module multichannel_adc_smoothing_filter_core #(
   parameter int CHANNELS     = 16,
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // request channel
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  madc_pkg::req_payload_type                  req_payload,
   // response channel
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output madc_pkg::rsp_payload_type                  rsp_payload,
   // configuration write port
   input  logic                                       csr_wr_en,
   input  logic [madc_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [madc_pkg::CSR_DATA_W-1:0]            csr_wdata
);
   import madc_pkg::*;

   // derived sizes
   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int LEN_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_DEPTH);
   localparam int WIN_N   = CHANNELS * WINDOW_DEPTH;
   localparam int WIN_AW  = (WIN_N > 1) ? $clog2(WIN_N) : 1;
   localparam int DVD_W   = SUM_W + FRAC_W;
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = RESULT_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // per-channel record held in the channel memory
   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [PTR_W-1:0]    ptr;
      logic [LEN_W-1:0]    fill;
      logic [LEN_W-1:0]    act_len;
      logic [RESULT_W-1:0] last;
   } chan_rec_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_CHAN = 8'b0000_0010,
      ST_WIN  = 8'b0000_0100,
      ST_DIV  = 8'b0000_1000,
      ST_MUL1 = 8'b0001_0000,
      ST_MUL2 = 8'b0010_0000,
      ST_SUM  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   // configuration registers
   logic        mode_ff;
   logic [7:0]  wlen_ff;
   logic [16:0] alpha_ff;

   // control
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff;
   logic [CHANNELS-1:0]   chan_vld_ff;

   // item context
   logic [SAMPLE_W-1:0]   x_ff;
   logic [CHAN_W-1:0]     chan_ff;
   logic                  drop_ff;
   chan_rec_type          rec_ff;
   logic [PTR_W-1:0]      slot_ff;
   logic [LEN_W-1:0]      n_ff;
   logic [WIN_AW-1:0]     win_addr_ff;
   logic [16:0]           alpha_c_ff;
   logic [PROD_W-1:0]     prod1_ff;
   logic [PROD_W-1:0]     prod2_ff;
   logic [RESULT_W-1:0]   result_ff;

   // memories
   logic [SAMPLE_W-1:0]   win_mem [WIN_N];
   logic [SAMPLE_W-1:0]   win_rd_ff;
   chan_rec_type          chan_mem [CHANNELS];
   chan_rec_type          chan_rd_ff;
   logic                  chan_rd_vld_ff;

   // combinational helpers
   logic                  req_accept;
   logic [CHAN_W-1:0]     in_chan;
   logic                  in_drop;
   logic [CH_W-1:0]       ch_idx;
   logic [CH_W-1:0]       in_ch_idx;
   logic [LEN_W-1:0]      n_clamp;
   logic [16:0]           alpha_clamp;
   chan_rec_type          rec_cur;
   chan_rec_type          rec_ma;
   logic [PTR_W-1:0]      slot;
   logic [WIN_AW-1:0]     win_addr_in;
   logic [SAMPLE_W-1:0]   old_val;
   logic [SUM_W-1:0]      new_sum;
   logic [LEN_W-1:0]      slot_inc;
   logic [PTR_W-1:0]      ptr_next;
   logic [LEN_W-1:0]      fill_next;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [PROD_W-1:0]     mul_p;
   logic [PROD_W:0]       acc;
   logic                  out_free;
   logic                  chan_we;
   logic                  win_we;
   logic                  div_start;
   div_status_type        div_stat;
   logic [DVD_W-1:0]      div_quo;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_MOVING_AVG;
         wlen_ff  <= WINDOW_LENGTH_RST;
         alpha_ff <= EMA_ALPHA_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FILTER_MODE:   mode_ff  <= csr_wdata[0];
            CSR_WINDOW_LENGTH: wlen_ff  <= csr_wdata[7:0];
            CSR_EMA_ALPHA:     alpha_ff <= csr_wdata[16:0];
            default: ;  // unused index, write ignored
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // request decode
   // ---------------------------------------------------------------------
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign in_chan    = req_payload.status[CHAN_W-1:0];
   assign in_drop    = {1'b0, in_chan} >= (CHAN_W + 1)'(CHANNELS);
   assign in_ch_idx  = in_chan[CH_W-1:0];
   assign ch_idx     = chan_ff[CH_W-1:0];

   // window length clamped to 1..WINDOW_DEPTH
   always_comb begin
      if (wlen_ff == 8'd0) begin
         n_clamp = LEN_W'(1);
      end else if ({1'b0, wlen_ff} > 9'(WINDOW_DEPTH)) begin
         n_clamp = LEN_W'(WINDOW_DEPTH);
      end else begin
         n_clamp = LEN_W'(wlen_ff);
      end
   end

   // alpha saturates at one
   assign alpha_clamp = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   // ---------------------------------------------------------------------
   // moving-average path
   // ---------------------------------------------------------------------
   // a channel never written reads as all zeros
   assign rec_cur = chan_rd_vld_ff ? chan_rd_ff : '0;

   // a new window length restarts the channel's window
   always_comb begin
      rec_ma = rec_cur;
      if (rec_cur.act_len != n_clamp) begin
         rec_ma.sum     = '0;
         rec_ma.ptr     = '0;
         rec_ma.fill    = '0;
         rec_ma.act_len = n_clamp;
      end
   end

   assign slot        = (LEN_W'(rec_ma.ptr) >= n_clamp) ? '0 : rec_ma.ptr;
   assign win_addr_in = WIN_AW'(ch_idx) * WIN_AW'(WINDOW_DEPTH) + WIN_AW'(slot);

   // slots past the fill count were never written since the last restart
   assign old_val   = (LEN_W'(slot_ff) < rec_ff.fill) ? win_rd_ff : '0;
   assign new_sum   = rec_ff.sum - SUM_W'(old_val) + SUM_W'(x_ff);
   assign slot_inc  = LEN_W'(slot_ff) + LEN_W'(1);
   assign ptr_next  = (slot_inc >= n_ff) ? '0 : PTR_W'(slot_inc);
   assign fill_next = (rec_ff.fill < n_ff) ? rec_ff.fill + LEN_W'(1) : rec_ff.fill;

   madc_divider #(
      .DIVIDEND_W (DVD_W),
      .DIVISOR_W  (LEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({new_sum, FRAC_W'(0)}),
      .divisor  (n_ff),
      .status   (div_stat),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------------
   // exponential path: one multiplier, used for both weighted terms
   // ---------------------------------------------------------------------
   always_comb begin
      if (state_ff == ST_MUL1) begin
         mul_a = alpha_c_ff;
         mul_b = {x_ff, FRAC_W'(0)};
      end else begin
         mul_a = ALPHA_ONE - alpha_c_ff;
         mul_b = rec_ff.last;
      end
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign acc   = {1'b0, prod1_ff} + {1'b0, prod2_ff};

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign chan_we   = (state_ff == ST_DONE) && out_free && !drop_ff;
   assign win_we    = (state_ff == ST_WIN);
   assign div_start = (state_ff == ST_WIN);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = in_drop ? ST_DONE : ST_CHAN;
            end
         end
         ST_CHAN: state_in = (mode_ff == MODE_EMA) ? ST_MUL1 : ST_WIN;
         ST_WIN:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chan_vld_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (chan_we) begin
            chan_vld_ff[ch_idx] <= 1'b1;
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            x_ff      <= req_payload.sample;
            chan_ff   <= in_chan;
            drop_ff   <= in_drop;
            result_ff <= '0;
         end
         ST_CHAN: begin
            alpha_c_ff <= alpha_clamp;
            n_ff       <= n_clamp;
            slot_ff    <= slot;
            if (mode_ff == MODE_EMA) begin
               rec_ff <= rec_cur;
            end else begin
               rec_ff <= rec_ma;
            end
            win_addr_ff <= win_addr_in;
         end
         ST_WIN: begin
            rec_ff.sum  <= new_sum;
            rec_ff.ptr  <= ptr_next;
            rec_ff.fill <= fill_next;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               result_ff <= div_quo[RESULT_W-1:0];
            end
         end
         ST_MUL1: prod1_ff <= mul_p;
         ST_MUL2: prod2_ff <= mul_p;
         ST_SUM:  result_ff <= acc[RESULT_W+15:16];
         ST_DONE: begin
            if (out_free) begin
               rsp_payload_ff.chan     <= chan_ff;
               rsp_payload_ff.smoothed <= result_ff;
               rsp_payload_ff.dropped  <= drop_ff;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // memories
   // ---------------------------------------------------------------------
   // raw sample window, read when the channel record arrives
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_addr_ff] <= x_ff;
      end
      if (state_ff == ST_CHAN) begin
         win_rd_ff <= win_mem[win_addr_in];
      end
   end

   // per-channel record, read on the request transfer, written at the end
   always_ff @(posedge clock) begin
      if (chan_we) begin
         chan_mem[ch_idx] <= '{sum:     rec_ff.sum,
                               ptr:     rec_ff.ptr,
                               fill:    rec_ff.fill,
                               act_len: rec_ff.act_len,
                               last:    result_ff};
      end
      if (req_accept) begin
         chan_rd_ff     <= chan_mem[in_ch_idx];
         chan_rd_vld_ff <= chan_vld_ff[in_ch_idx];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_chan_wr_done: assert property (@(posedge clock) disable iff (reset)
      chan_we |-> (state_ff == ST_DONE) && !drop_ff)
      else $error("channel record written outside completion");

   a_win_wr_ma: assert property (@(posedge clock) disable iff (reset)
      win_we |-> (mode_ff == MODE_MOVING_AVG) && !drop_ff)
      else $error("window written for an exponential or dropped item");

   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_drop_to_done: assert property (@(posedge clock) disable iff (reset)
      req_accept && in_drop |=> (state_ff == ST_DONE))
      else $error("dropped item did not go straight to completion");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.dropped |-> (rsp_payload_ff.smoothed == '0))
      else $error("dropped response carries a nonzero value");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multichannel adc smoothing filter core
// ----------------------------------------------------------------------------
// A short table of hand-picked transfers and register writes comes first.
// After it, random phases follow. Each phase picks a filter mode, a window
// length and an alpha, then sends a burst of conversion words. Most bursts
// stay on a few channels, so that windows fill and wrap. Every accepted
// request runs through a local model of the per-channel filter state. Each
// response transfer is compared field by field against the oldest pending
// prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import madc_pkg::*;

   localparam int CHANNELS     = 16;
   localparam int WINDOW_DEPTH = 16;
   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PRINT_LIMIT  = 40;

   // index past the register list, must be ignored by the core
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      idx;
      logic [CSR_DATA_W-1:0]     wdata;
      req_payload_type           item;
      logic                      typed;
      logic [RESULT_W-1:0]       want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   // local copy of the filter registers
   logic                  mode_q  = MODE_MOVING_AVG;
   logic [7:0]            len_q   = WINDOW_LENGTH_RST;
   logic [16:0]           alpha_q = EMA_ALPHA_RST;

   // local copy of the per-channel filter state
   logic [SAMPLE_W-1:0]   win_samples [CHANNELS][WINDOW_DEPTH];
   logic [31:0]           win_total [CHANNELS];
   int unsigned           win_head [CHANNELS];
   int unsigned           win_len_used [CHANNELS];
   logic [RESULT_W-1:0]   prev_smoothed [CHANNELS];

   rsp_payload_type       expected_rsp [$];
   plan_row_type          plan [$];

   logic calm = 1'b0;
   int   mismatch_count = 0;
   int   checked_count  = 0;
   int   cycle_count    = 0;

   multichannel_adc_smoothing_filter_core #(
      .CHANNELS     (CHANNELS),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, expected_rsp.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h",
                  $time, what, got, want);
   endtask

   // one step of the filter for an accepted request, updates the local state
   function automatic rsp_payload_type predict_smoothed(input req_payload_type item);
      rsp_payload_type r;
      logic [CHAN_W-1:0]   ch;
      logic [SAMPLE_W-1:0] x;
      int unsigned         n;
      int unsigned         p;
      logic [63:0]         a;
      logic [63:0]         acc;
      ch         = item.status[CHAN_W-1:0];
      x          = item.sample;
      r.chan     = ch;
      r.smoothed = '0;
      r.dropped  = 1'b0;
      if (int'(ch) >= CHANNELS) begin
         // out-of-range channel: flagged, state untouched
         r.dropped = 1'b1;
         return r;
      end
      if (mode_q == MODE_EMA) begin
         a   = (alpha_q > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_q);
         acc = a * (64'(x) << FRAC_W) + (64'(ALPHA_ONE) - a) * 64'(prev_smoothed[ch]);
         r.smoothed = acc[47:16];
      end else begin
         if (len_q == 0)
            n = 1;
         else if (len_q > WINDOW_DEPTH)
            n = WINDOW_DEPTH;
         else
            n = len_q;
         // new window length restarts the channel window from zero
         if (win_len_used[ch] != n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
               win_samples[ch][i] = '0;
            win_total[ch]    = '0;
            win_head[ch]     = 0;
            win_len_used[ch] = n;
         end
         p = win_head[ch];
         if (p >= n)
            p = 0;
         win_total[ch]      = win_total[ch] - 32'(win_samples[ch][p]) + 32'(x);
         win_samples[ch][p] = x;
         p++;
         if (p >= n)
            p = 0;
         win_head[ch] = p;
         acc = (64'(win_total[ch]) << FRAC_W) / 64'(n);
         r.smoothed = acc[31:0];
      end
      prev_smoothed[ch] = r.smoothed;
      return r;
   endfunction

   function automatic plan_row_type cfg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      plan_row_type r;
      r       = '{kind: ROW_CFG, default: '0};
      r.kind  = ROW_CFG;
      r.idx   = idx;
      r.wdata = val;
      return r;
   endfunction

   function automatic plan_row_type item_row(input logic [SAMPLE_W-1:0] s,
                                             input logic [STATUS_W-1:0] st,
                                             input logic typed,
                                             input logic [RESULT_W-1:0] want);
      plan_row_type r;
      r             = '{kind: ROW_ITEM, default: '0};
      r.kind        = ROW_ITEM;
      r.item.sample = s;
      r.item.status = st;
      r.typed       = typed;
      r.want        = want;
      return r;
   endfunction

   // register writes only happen with nothing in flight
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_FILTER_MODE:   mode_q  = val[0];
         CSR_WINDOW_LENGTH: len_q   = val[7:0];
         CSR_EMA_ALPHA:     alpha_q = val;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // offer one request, predict its response once the transfer happens
   task automatic send_sample(input req_payload_type item, input logic typed,
                              input logic [RESULT_W-1:0] want);
      rsp_payload_type predicted;
      if (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = predict_smoothed(item);
      if (typed)
         predicted.smoothed = want;
      expected_rsp.push_back(predicted);
   endtask

   // receiver is not ready about a fifth of the time, except in the calm stretch
   always @(posedge clock)
      rsp_ready <= calm || ($urandom_range(0, 99) >= 20);

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_payload.smoothed, '0);
         end else begin
            want = expected_rsp.pop_front();
            checked_count++;
            if (rsp_payload.chan !== want.chan)
               report_mismatch("chan", rsp_payload.chan, want.chan);
            if (rsp_payload.smoothed !== want.smoothed)
               report_mismatch("smoothed", rsp_payload.smoothed, want.smoothed);
            if (rsp_payload.dropped !== want.dropped)
               report_mismatch("dropped", rsp_payload.dropped, want.dropped);
         end
      end
   end

   initial begin
      req_payload_type     item;
      logic [CHAN_W-1:0]   base_ch;
      logic [CHAN_W-1:0]   ch;
      logic [SAMPLE_W-1:0] last_sample;
      logic [7:0]          len_pick;
      logic [16:0]         alpha_pick;
      int                  span;
      int                  burst;
      int                  directed_sent;
      int                  rand_sent;
      int                  phases;

      for (int c = 0; c < CHANNELS; c++) begin
         for (int i = 0; i < WINDOW_DEPTH; i++)
            win_samples[c][i] = '0;
         win_total[c]     = '0;
         win_head[c]      = 0;
         win_len_used[c]  = 0;
         prev_smoothed[c] = '0;
      end
      directed_sent = 0;
      rand_sent     = 0;
      phases        = 0;
      last_sample   = '0;

      // defaults after reset: moving average over 16 words
      plan.push_back(item_row(24'h000000, 8'h00, 1'b1, 32'h0000_0000));
      plan.push_back(item_row(24'hFFFFFF, 8'hF1, 1'b1, 32'h0FFF_FFF0));
      plan.push_back(item_row(24'hFFFFFF, 8'h0F, 1'b1, 32'h0FFF_FFF0));
      plan.push_back(item_row(24'h800000, 8'h01, 1'b1, 32'h17FF_FFF0));
      // zero length acts as one, the window restarts
      plan.push_back(cfg_row(CSR_WINDOW_LENGTH, 17'd0));
      plan.push_back(item_row(24'hFFFFFF, 8'h81, 1'b1, 32'hFFFF_FF00));
      plan.push_back(item_row(24'h000001, 8'h01, 1'b1, 32'h0000_0100));
      // short window that wraps, upper data bits must be ignored
      plan.push_back(cfg_row(CSR_WINDOW_LENGTH, 17'h1FF03));
      plan.push_back(item_row(24'h000300, 8'h02, 1'b0, '0));
      plan.push_back(item_row(24'hFFFFFF, 8'h42, 1'b0, '0));
      plan.push_back(item_row(24'h123456, 8'h02, 1'b0, '0));
      plan.push_back(item_row(24'h000001, 8'hA2, 1'b0, '0));
      plan.push_back(item_row(24'hABCDEF, 8'h02, 1'b0, '0));
      // oversized length clamps to the window depth
      plan.push_back(cfg_row(CSR_WINDOW_LENGTH, 17'd255));
      plan.push_back(item_row(24'h00FF00, 8'h22, 1'b0, '0));
      // exponential mode, alpha extremes
      plan.push_back(cfg_row(CSR_FILTER_MODE, 17'(MODE_EMA)));
      plan.push_back(cfg_row(CSR_EMA_ALPHA, 17'd65536));
      plan.push_back(item_row(24'hFFFFFF, 8'h03, 1'b1, 32'hFFFF_FF00));
      plan.push_back(cfg_row(CSR_EMA_ALPHA, 17'd0));
      plan.push_back(item_row(24'h123456, 8'h13, 1'b1, 32'hFFFF_FF00));
      // alpha above one acts as one
      plan.push_back(cfg_row(CSR_EMA_ALPHA, 17'h1FFFF));
      plan.push_back(item_row(24'h000010, 8'h33, 1'b1, 32'h0000_1000));
      plan.push_back(cfg_row(CSR_EMA_ALPHA, 17'd1));
      plan.push_back(item_row(24'hFFFFFF, 8'h03, 1'b0, '0));
      plan.push_back(cfg_row(CSR_EMA_ALPHA, 17'd32768));
      plan.push_back(item_row(24'hFFFFFF, 8'hC4, 1'b1, 32'h7FFF_FF80));
      plan.push_back(item_row(24'h000000, 8'h01, 1'b1, 32'h0000_0080));
      // write past the register list, then back to moving average
      plan.push_back(cfg_row(CSR_UNUSED_IDX, 17'h1FFFF));
      plan.push_back(cfg_row(CSR_FILTER_MODE, 17'h1FFFE));
      plan.push_back(item_row(24'h000002, 8'h01, 1'b1, 32'h0000_0020));
      plan.push_back(item_row(24'hFFFFFF, 8'hF0, 1'b1, 32'h0FFF_FFF0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            wait_idle();
            write_csr(plan[i].idx, plan[i].wdata);
         end else begin
            send_sample(plan[i].item, plan[i].typed, plan[i].want);
            directed_sent++;
         end
      end

      // random phases, each with its own filter setting
      while (rand_sent < RANDOM_ITEMS) begin
         wait_idle();
         phases++;
         write_csr(CSR_FILTER_MODE, {16'($urandom), $urandom_range(0, 99) < 40});
         case ($urandom_range(0, 7))
            0:       len_pick = 8'd0;
            1:       len_pick = 8'd1;
            2:       len_pick = 8'd15;
            3:       len_pick = 8'd16;
            4:       len_pick = 8'd17;
            5:       len_pick = 8'd255;
            default: len_pick = 8'($urandom_range(0, 255));
         endcase
         write_csr(CSR_WINDOW_LENGTH, {9'($urandom), len_pick});
         case ($urandom_range(0, 8))
            0:       alpha_pick = 17'd0;
            1:       alpha_pick = 17'd1;
            2:       alpha_pick = 17'd65535;
            3:       alpha_pick = 17'd65536;
            4:       alpha_pick = 17'd65537;
            5:       alpha_pick = 17'h1FFFF;
            default: alpha_pick = 17'($urandom);
         endcase
         write_csr(CSR_EMA_ALPHA, alpha_pick);
         if ($urandom_range(0, 9) == 0)
            write_csr(CSR_UNUSED_IDX, 17'($urandom));

         // most bursts stay on a few channels so windows fill and wrap
         base_ch = 4'($urandom);
         span    = ($urandom_range(0, 99) < 65) ? $urandom_range(1, 3) : CHANNELS;
         burst   = $urandom_range(10, 60);
         for (int k = 0; k < burst && rand_sent < RANDOM_ITEMS; k++) begin
            calm = (rand_sent >= 300 && rand_sent < 450);
            ch   = base_ch + 4'($urandom_range(0, span - 1));
            case ($urandom_range(0, 9))
               0:       item.sample = '0;
               1:       item.sample = '1;
               2:       item.sample = last_sample;
               default: item.sample = 24'($urandom);
            endcase
            item.status = {4'($urandom), ch};
            last_sample = item.sample;
            send_sample(item, 1'b0, '0);
            rand_sent++;
         end
      end
      calm = 1'b0;

      wait_idle();
      repeat (50) @(posedge clock);

      $display("sent %0d table and %0d random samples across %0d random filter settings",
               directed_sent, rand_sent, phases);
      $display("checked %0d responses, %0d mismatches", checked_count, mismatch_count);
      if (mismatch_count == 0 && expected_rsp.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
